/* hdl/fpa_pkg.sv */
// Package for the fixed-point ALU: opcodes and status codes.
// Used by fpa_div_unit and fixed_point_alu_unit.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

endpackage

/* hdl/fixed_point_alu_unit.sv */
// Fixed-point ALU top level: a first stage, the divider stages and a final stage.
// Depends on fpa_pkg and fpa_div_unit.
//
// One item enters per cycle unless the output stalls; the whole pipe advances
// together and holds on a stall of the output, so throughput is one item a
// cycle while the output is not stalled. The depth is set by the divider,
// which resolves one quotient bit per stage; other ops ride along in a delay
// line. Stage one forms magnitudes and the product, the divider follows,
// then rounding, sign and the saturation clamp.
module fixed_point_alu_unit
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] operand_a,
  input  logic signed [WORD_BITS-1:0] operand_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] result_raw,
  output logic                        compare_true,
  output logic [1:0]                  status
);

  localparam int NB    = WORD_BITS + FRAC_BITS;   // divider numerator width
  localparam int DEPTH = NB + 1;                  // stages before final
  localparam int XW    = WORD_BITS + FRAC_BITS + 2; // wide signed value

  typedef struct packed {
    logic [3:0]            op;
    logic                  neg;   // sign of div result
    logic                  div0;
    logic                  cmp;
    logic signed [XW-1:0]  val;   // result of ops other than mul and div, not yet clamped
  } side_t;

  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // stage 1: decode, magnitudes, multiply
  logic [DEPTH-1:0] vld;
  side_t side [DEPTH];
  logic signed [2*WORD_BITS-1:0] prod_q;
  logic signed [XW-1:0] v_c;
  logic cmp_c;
  logic [WORD_BITS-1:0] mag_a, mag_b;
  logic signed [WORD_BITS:0] a_x, b_x;

  always_comb begin
    a_x   = {operand_a[WORD_BITS-1], operand_a};
    b_x   = {operand_b[WORD_BITS-1], operand_b};
    mag_a = operand_a[WORD_BITS-1] ? WORD_BITS'(-a_x) : operand_a;
    mag_b = operand_b[WORD_BITS-1] ? WORD_BITS'(-b_x) : operand_b;
    v_c   = '0;
    cmp_c = 1'b0;
    case (op_t'(req_type))
      OP_ADD:      v_c = XW'(a_x + b_x);
      OP_SUB:      v_c = XW'(a_x - b_x);
      OP_GT:       cmp_c = operand_a >  operand_b;
      OP_LT:       cmp_c = operand_a <  operand_b;
      OP_GE:       cmp_c = operand_a >= operand_b;
      OP_LE:       cmp_c = operand_a <= operand_b;
      OP_EQ:       cmp_c = operand_a == operand_b;
      OP_NE:       cmp_c = operand_a != operand_b;
      OP_MIN:      v_c = (operand_a < operand_b) ? XW'(operand_a) : XW'(operand_b);
      OP_MAX:      v_c = (operand_a > operand_b) ? XW'(operand_a) : XW'(operand_b);
      OP_INC:      v_c = XW'(a_x + 1);
      OP_DEC:      v_c = XW'(a_x - 1);
      OP_FROM_INT: v_c = XW'(operand_a) <<< FRAC_BITS;
      OP_TO_INT:   v_c = XW'(operand_a) >>> FRAC_BITS;
      default:     v_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].op   <= req_type;
      side[0].neg  <= operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1];
      side[0].div0 <= (operand_b == '0);
      side[0].cmp  <= cmp_c;
      side[0].val  <= v_c;
      prod_q       <= operand_a * operand_b;
      for (int i = 1; i < DEPTH; i++) side[i] <= side[i-1];
    end
  end

  // multiply rounding rides the delay line: computed from the registered product
  localparam int PW = 2 * WORD_BITS;
  logic [PW-1:0] pmag;
  logic [PW-1:0] pq;
  logic          pneg;
  logic signed [XW-1:0] mul_val;
  logic signed [XW-1:0] mul_line [DEPTH-1];
  always_comb begin
    pneg = prod_q[PW-1];
    pmag = pneg ? PW'(-prod_q) : PW'(prod_q);
    pq   = pmag >> FRAC_BITS;
    if (FRAC_BITS > 0) pq = pq + PW'(pmag[(FRAC_BITS > 0 ? FRAC_BITS-1 : 0)]);
    // clamp magnitude to what XW holds, keeping saturation visible
    if (pq > PW'({1'b0, {(XW-2){1'b1}}})) pq = PW'({1'b0, {(XW-2){1'b1}}});
    mul_val = pneg ? -XW'(pq) : XW'(pq);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mul_line[0] <= mul_val;
      for (int i = 1; i < DEPTH-1; i++) mul_line[i] <= mul_line[i-1];
    end
  end

  // divider: fed from registered magnitudes of stage 1
  logic [WORD_BITS-1:0] dmag_a, dmag_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_a <= mag_a;
      dmag_b <= mag_b;
    end
  end
  logic [NB-1:0]        quo;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] den_line [NB];
  always_ff @(posedge clk) begin
    if (adv) begin
      den_line[0] <= dmag_b;
      for (int i = 1; i < NB; i++) den_line[i] <= den_line[i-1];
    end
  end

  fpa_div_unit #(.NUM_BITS(NB), .DEN_BITS(WORD_BITS)) u_div (
    .clk (clk),
    .adv (adv),
    .num ({dmag_a, {FRAC_BITS{1'b0}}}),
    .den (dmag_b),
    .quo (quo),
    .rem (rem)
  );

  // final stage: round divide, select, clamp
  side_t s;
  logic [NB:0] dq;
  logic [WORD_BITS:0] r2;
  logic signed [XW-1:0] fv;
  logic signed [WORD_BITS-1:0] res_c;
  logic [1:0] st_c;
  logic cmp_out;
  localparam logic signed [XW-1:0] HI = XW'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic signed [XW-1:0] LO = -HI - XW'(1);

  always_comb begin
    s  = side[DEPTH-1];
    r2 = {rem, 1'b0};
    dq = {1'b0, quo} + ((r2 >= {1'b0, den_line[NB-1]}) ? (NB+1)'(1) : '0);
    fv = s.val;
    if (op_t'(s.op) == OP_MUL) fv = mul_line[DEPTH-2];
    if (op_t'(s.op) == OP_DIV) fv = s.neg ? -XW'(dq) : XW'(dq);
    res_c   = '0;
    st_c    = ST_OK;
    cmp_out = 1'b0;
    case (op_t'(s.op)) inside
      [OP_GT:OP_NE]: cmp_out = s.cmp;
      default: begin
        if (op_t'(s.op) == OP_DIV && s.div0) begin
          st_c = ST_DIV0;
        end else if (fv > HI) begin
          res_c = HI[WORD_BITS-1:0];
          st_c  = ST_SAT;
        end else if (fv < LO) begin
          res_c = LO[WORD_BITS-1:0];
          st_c  = ST_SAT;
        end else begin
          res_c = fv[WORD_BITS-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_raw   <= res_c;
      compare_true <= cmp_out;
      status       <= st_c;
    end
  end

  // a stalled output holds its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_raw))
    else $error("output item changed while stalled");
  // a true comparison carries status OK and a zero result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> status == ST_OK && result_raw == '0)
    else $error("comparison item carries a value");
  // divide by zero gives zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIV0 |-> result_raw == '0 && !compare_true)
    else $error("divide by zero item not cleared");

endmodule

/* hdl/fpa_div_unit.sv */
// Pipelined restoring divider, one quotient bit per stage, magnitude only.
// Depends on fpa_pkg (shared import convention). Advances when adv is high.
module fpa_div_unit
  import fpa_pkg::*;
#(
  parameter int NUM_BITS = 40,
  parameter int DEN_BITS = 32
) (
  input  logic                clk,
  input  logic                adv,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo,
  output logic [DEN_BITS-1:0] rem
);

  logic [NUM_BITS-1:0] q_st [NUM_BITS+1];
  logic [DEN_BITS:0]   r_st [NUM_BITS+1];
  logic [DEN_BITS-1:0] d_st [NUM_BITS+1];

  assign q_st[0] = num;
  assign r_st[0] = '0;
  assign d_st[0] = den;

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS+1:0] diff;
    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0]   r_reg;
    logic [DEN_BITS-1:0] d_reg;
    always_comb begin
      trial = {r_st[i][DEN_BITS-1:0], q_st[i][NUM_BITS-1]};
      diff  = {1'b0, trial} - {2'b00, d_st[i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_reg <= d_st[i];
        if (!diff[DEN_BITS+1]) begin
          r_reg <= diff[DEN_BITS:0];
          q_reg <= {q_st[i][NUM_BITS-2:0], 1'b1};
        end else begin
          r_reg <= trial;
          q_reg <= {q_st[i][NUM_BITS-2:0], 1'b0};
        end
      end
    end
    assign q_st[i+1] = q_reg;
    assign r_st[i+1] = r_reg;
    assign d_st[i+1] = d_reg;
  end

  assign quo = q_st[NUM_BITS];
  assign rem = r_st[NUM_BITS][DEN_BITS-1:0];

endmodule

/* verif/fixed_point_alu_unit_tb.sv */
// Testbench for fixed_point_alu_unit: Q24.8 ALU requests checked against an exact predictor.
// Depends on fpa_pkg and the RTL of fixed_point_alu_unit; uses a small scoreboard class.
`timescale 1ns / 100ps

module fixed_point_alu_unit_tb;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 41;

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
    logic [1:0]         code;
  } alu_answer_t;

  // Exact model of one request; 64-bit intermediates, then the word clamp.
  function automatic alu_answer_t alu_predict(op_t op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_answer_t r;
    longint x, y, v, p, q, rem;
    longint unsigned mag, num, den;
    bit neg;
    x = a;
    y = b;
    v = 0;
    r.flag = 1'b0;
    r.code = ST_OK;
    case (op)
      OP_ADD: v = x + y;
      OP_SUB: v = x - y;
      OP_MUL: begin
        p = x * y;
        mag = (p < 0) ? -p : p;
        q = mag >> FRAC;
        if (mag[FRAC-1]) q++;
        v = (p < 0) ? -q : q;
      end
      OP_DIV: begin
        if (y != 0) begin
          num = ((x < 0) ? -x : x) << FRAC;
          den = (y < 0) ? -y : y;
          q = num / den;
          rem = num % den;
          if (rem >= den - rem) q++;
          neg = (x < 0) != (y < 0);
          v = neg ? -q : q;
        end
      end
      OP_GT: r.flag = x > y;
      OP_LT: r.flag = x < y;
      OP_GE: r.flag = x >= y;
      OP_LE: r.flag = x <= y;
      OP_EQ: r.flag = x == y;
      OP_NE: r.flag = x != y;
      OP_MIN: v = (x < y) ? x : y;
      OP_MAX: v = (x > y) ? x : y;
      OP_INC: v = x + 1;
      OP_DEC: v = x - 1;
      OP_FROM_INT: v = x * (64'sd1 <<< FRAC);
      default: v = x >>> FRAC;
    endcase
    if (op == OP_DIV && y == 0) begin
      v = 0;
      r.code = ST_DIV0;
    end else if (op inside {[OP_GT:OP_NE]}) begin
      v = 0;
    end else if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.code = ST_SAT;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.code = ST_SAT;
    end
    r.value = v[31:0];
    return r;
  endfunction

  class alu_scoreboard;
    alu_answer_t pending[$];
    int errors;
    int checked;

    function void note_request(op_t op, logic signed [31:0] a, logic signed [31:0] b);
      pending.push_back(alu_predict(op, a, b));
    endfunction

    function void check_answer(alu_answer_t got);
      alu_answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item value=%0d flag=%0b code=%0d",
                 $time, got.value, got.flag, got.code);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.value !== got.value) begin
        $display("%0t: result_raw expected %0d got %0d", $time, want.value, got.value);
        errors++;
      end
      if (want.flag !== got.flag) begin
        $display("%0t: compare_true expected %0b got %0b", $time, want.flag, got.flag);
        errors++;
      end
      if (want.code !== got.code) begin
        $display("%0t: status expected %0d got %0d", $time, want.code, got.code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] req_type = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_raw;
  logic compare_true;
  logic [1:0] status;

  alu_scoreboard board = new();
  bit calm = 0;      // no idling on either side in the last part
  int drained_wait;

  fixed_point_alu_unit u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note each request and check each result at the edge where its handshake fires.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      board.note_request(op_t'(req_type), operand_a, operand_b);
    if (!rst && out_valid && out_ready)
      board.check_answer('{result_raw, compare_true, status});
  end

  // Receiver: ready drops in random bursts until the calm phase.
  initial begin
    int hold;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Present one item; hold it until it is taken.
  task automatic send_item(op_t op, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Skew operands toward the edges, small values and zero.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 1024)) - 512;
      3: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      4: return 0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] hi, lo;
    hi = 32'sh7fffffff;
    lo = 32'sh80000000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every opcode, field extremes, zero divide, clamps, ties.
    for (int k = 0; k < 16; k++) send_item(op_t'(k), hi, lo);
    send_item(OP_DIV, 32'sd256, 32'sd0);
    send_item(OP_ADD, hi, 32'sd1);
    send_item(OP_SUB, lo, 32'sd1);
    send_item(OP_MUL, 32'sd384, -32'sd1);
    send_item(OP_DIV, 32'sd1, 32'sd512);
    send_item(OP_INC, hi, 32'sd0);
    send_item(OP_DEC, lo, 32'sd0);
    send_item(OP_FROM_INT, -32'sd8388609, 32'sd0);
    send_item(OP_TO_INT, -32'sd1, 32'sd0);

    // Random requests; after 600 of them, stop and wait for the pipe to drain.
    for (int n = 0; n < 1250; n++) begin
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
      end
      if (n == 1000) calm = 1;
      send_item(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    drained_wait = 0;
    while (board.pending.size() != 0 && drained_wait < 20000) begin
      @(posedge clk);
      drained_wait++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.pending.size());
      board.errors++;
    end
    $display("Covered all 16 opcodes with edge and random operands; %0d results compared.",
             board.checked);
    if (board.errors == 0)
      $display("fixed_point_alu_unit_tb: done, clean");
    else
      $display("fixed_point_alu_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("fixed_point_alu_unit_tb: done, errors");
    $finish;
  end
endmodule

/* fixed_point_alu_unit.f */
hdl/fpa_pkg.sv
hdl/fpa_div_unit.sv
hdl/fixed_point_alu_unit.sv
verif/fixed_point_alu_unit_tb.sv
